// ===== rtl/dmr_pkg.sv =====
// Shared types and constants for the dual receive unit block.
// No dependencies; imported by dmr_unit and dual_midi_receiver_with_fifo.
package dmr_pkg;

  // action codes on the request channel
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  // register select, offset bits 1:0
  localparam logic [1:0] REG_STATUS = 2'd0;
  localparam logic [1:0] REG_CTRL   = 2'd1;
  localparam logic [1:0] REG_DATA   = 2'd3;

  localparam logic [7:0] STATUS_BASE = 8'hC0;
  localparam int         CTRL_BIT    = 0;

  // per-unit command for one accepted beat
  typedef struct packed {
    logic       read;
    logic       push;
    logic [1:0] reg_sel;
    logic [7:0] rx_byte;
  } unit_cmd_t;

  // per-unit response: read data from before the beat, pending flag after it
  typedef struct packed {
    logic [7:0] read_data;
    logic       pending;
    logic       overflow;
  } unit_rsp_t;

endpackage

// ===== rtl/dmr_req_if.sv =====
// Request channel: valid/ready handshake with one bus access or received byte.
// No dependencies.
interface dmr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] offset;
  logic [7:0] write_data;
  logic       rx_unit;
  logic [7:0] rx_byte;

  modport source (output valid, action, offset, write_data, rx_unit, rx_byte,
                  input ready);
  modport sink   (input valid, action, offset, write_data, rx_unit, rx_byte,
                  output ready);
endinterface

// ===== rtl/dmr_rsp_if.sv =====
// Response channel: valid/ready handshake with one result per request beat.
// No dependencies.
interface dmr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;
  logic       overflow;
  logic       drive_select;
  logic       disk_side;

  modport source (output valid, read_data, irq, overflow, drive_select, disk_side,
                  input ready);
  modport sink   (input valid, read_data, irq, overflow, drive_select, disk_side,
                  output ready);
endinterface

// ===== rtl/dmr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dmr_unit.sv =====
// One receive unit: byte FIFO (RAM plus head register) feeding the data register.
// Depends on dmr_pkg and dmr_ram.
module dmr_unit import dmr_pkg::*; #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  unit_cmd_t cmd,
  output unit_rsp_t rsp
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [AW-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [7:0]    head, head_next, ram_q, data, data_next;
  logic          head_vld, head_vld_next;
  logic          fetch_pend, fetch_pend_next;   // head byte sits on ram_q
  logic          full, full_next, pending, pending_next;

  logic       avail, mem_empty, fifo_full, do_push, refill, consume, fetch, mem_we;
  logic       pend_a, full_a;
  logic [7:0] head_data;

  dmr_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (cmd.rx_byte),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    avail     = head_vld | fetch_pend;
    head_data = fetch_pend ? ram_q : head;
    mem_empty = (rd_ptr == wr_ptr);
    fifo_full = (cnt == CW'(FIFO_DEPTH));
    do_push   = cmd.push & ~fifo_full;

    pend_a = pending & ~(cmd.read & (cmd.reg_sel == REG_STATUS));
    full_a = full & ~(cmd.read & (cmd.reg_sel == REG_DATA));
    refill = ~pend_a & ~full_a & ((cmd.read & avail) | do_push);
    consume = refill & avail;

    head_next       = head;
    head_vld_next   = head_vld;
    fetch_pend_next = 1'b0;
    fetch           = 1'b0;
    mem_we          = 1'b0;

    if (consume) begin
      if (do_push && mem_empty) begin
        head_next     = cmd.rx_byte;
        head_vld_next = 1'b1;
      end else if (!mem_empty) begin
        fetch           = 1'b1;
        fetch_pend_next = 1'b1;
        head_vld_next   = 1'b0;
        mem_we          = do_push;
      end else begin
        head_vld_next = 1'b0;
      end
    end else begin
      if (fetch_pend) begin
        head_next     = ram_q;
        head_vld_next = 1'b1;
      end
      if (do_push) begin
        if (avail) begin
          mem_we = 1'b1;
        end else if (!refill) begin
          head_next     = cmd.rx_byte;
          head_vld_next = 1'b1;
        end
      end
    end

    wr_ptr_next  = mem_we ? ptr_inc(wr_ptr) : wr_ptr;
    rd_ptr_next  = fetch ? ptr_inc(rd_ptr) : rd_ptr;
    cnt_next     = cnt + CW'(do_push) - CW'(refill);
    data_next    = refill ? (avail ? head_data : cmd.rx_byte) : data;
    full_next    = refill | full_a;
    pending_next = refill | pend_a;

    rsp.read_data = '0;
    if (cmd.read) begin
      unique case (cmd.reg_sel)
        REG_STATUS: rsp.read_data = STATUS_BASE | {7'd0, full};
        REG_DATA:   rsp.read_data = data;
        default:    rsp.read_data = '0;
      endcase
    end
    rsp.pending  = pending_next;
    rsp.overflow = cmd.push & fifo_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      cnt        <= '0;
      head_vld   <= 1'b0;
      fetch_pend <= 1'b0;
      full       <= 1'b0;
      pending    <= 1'b0;
      data       <= '0;
    end else begin
      wr_ptr     <= wr_ptr_next;
      rd_ptr     <= rd_ptr_next;
      cnt        <= cnt_next;
      head_vld   <= head_vld_next;
      fetch_pend <= fetch_pend_next;
      full       <= full_next;
      pending    <= pending_next;
      data       <= data_next;
    end
    head <= head_next;
  end

  // head byte is present exactly when the FIFO holds anything
  a_head_avail: assert property (@(posedge clk) disable iff (rst)
    (head_vld | fetch_pend) == (cnt != '0))
    else $error("head presence disagrees with count");

  // RAM holds everything but the head
  a_mem_count: assert property (@(posedge clk) disable iff (rst)
    mem_empty == (cnt == CW'(head_vld | fetch_pend)))
    else $error("RAM pointers disagree with count");

  a_refill_sets: assert property (@(posedge clk) disable iff (rst)
    refill |=> (pending && full))
    else $error("refill did not set pending and full");

  a_ovf_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && fifo_full) |=> (cnt == CW'(FIFO_DEPTH)))
    else $error("dropped byte changed FIFO count");

endmodule

// ===== rtl/dual_midi_receiver_with_fifo.sv =====
// Dual receive unit with byte FIFOs. A result is valid in the cycle after its
// beat is accepted. Throughput: one beat per cycle; the output register
// takes the next result in the cycle the current one is taken, so req.ready
// only drops while a result waits. Reset clears pointers, counts, flags, data
// registers and control latches at once; FIFO RAM contents are not cleared.
// Depends on dmr_pkg, dmr_req_if, dmr_rsp_if, dmr_unit.
module dual_midi_receiver_with_fifo import dmr_pkg::*; #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic  clk,
  input  logic  rst,
  dmr_req_if.sink   req,
  dmr_rsp_if.source rsp
);

  unit_cmd_t cmd [2];
  unit_rsp_t ursp [2];
  logic      accept;
  logic      sel_latch, sel_latch_next, side_latch, side_latch_next;

  assign req.ready = ~rsp.valid | rsp.ready;
  assign accept    = req.valid & req.ready;

  for (genvar u = 0; u < 2; u++) begin : g_unit
    always_comb begin
      cmd[u].read    = accept && (req.action == ACT_READ) && (req.offset[2] == 1'(u));
      cmd[u].push    = accept && (req.action == ACT_RX) && (req.rx_unit == 1'(u));
      cmd[u].reg_sel = req.offset[1:0];
      cmd[u].rx_byte = req.rx_byte;
    end

    dmr_unit #(.FIFO_DEPTH(FIFO_DEPTH)) u_unit (
      .clk (clk),
      .rst (rst),
      .cmd (cmd[u]),
      .rsp (ursp[u])
    );
  end

  always_comb begin
    sel_latch_next  = sel_latch;
    side_latch_next = side_latch;
    if (accept && (req.action == ACT_WRITE) && (req.offset[1:0] == REG_CTRL)) begin
      if (req.offset[2]) begin
        side_latch_next = req.write_data[CTRL_BIT];
      end else begin
        sel_latch_next = req.write_data[CTRL_BIT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid  <= 1'b0;
      sel_latch  <= 1'b0;
      side_latch <= 1'b0;
    end else begin
      sel_latch  <= sel_latch_next;
      side_latch <= side_latch_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp.read_data    <= ursp[0].read_data | ursp[1].read_data;
      rsp.irq          <= ursp[0].pending | ursp[1].pending;
      rsp.overflow     <= ursp[0].overflow | ursp[1].overflow;
      rsp.drive_select <= sel_latch_next;
      rsp.disk_side    <= side_latch_next;
    end
  end

  a_ctrl_write: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action == ACT_WRITE) && (req.offset == {1'b0, REG_CTRL}))
    |=> (rsp.drive_select == $past(req.write_data[CTRL_BIT])))
    else $error("drive select not latched from control write");

  a_side_write: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action == ACT_WRITE) && (req.offset == {1'b1, REG_CTRL}))
    |=> (rsp.disk_side == $past(req.write_data[CTRL_BIT])))
    else $error("disk side not latched from control write");

  // a waiting result holds still until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready)
    |=> (rsp.valid && $stable(rsp.read_data) && $stable(rsp.irq) && $stable(rsp.overflow)))
    else $error("result changed while waiting");

endmodule
